/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the servo bus write framer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBWPF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbwpf assertion failed");

// next-cycle implication, disabled during reset
`define SBWPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbwpf assertion failed");

`endif

/* src/sbwpf_pkg.sv */
// ----------------------------------------------------------------------------
// sbwpf_pkg
// types and constants for the servo bus write packet framer
// ----------------------------------------------------------------------------
package sbwpf_pkg;

    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] INSTR_WRITE = 8'h03;
    localparam logic [7:0] ADDR_TORQUE = 8'h28;
    localparam logic [7:0] ADDR_ACCEL  = 8'h29;
    localparam logic [7:0] ADDR_POS    = 8'h2A;
    localparam logic [7:0] LEN_SHORT   = 8'd4;
    localparam logic [7:0] LEN_LONG    = 8'd7;
    localparam logic [3:0] LAST_SHORT  = 4'd7;
    localparam logic [3:0] LAST_LONG   = 4'd10;
    localparam logic [3:0] DATA_START  = 4'd6;

    typedef enum logic [1:0] {
        OP_TORQUE = 2'd0,
        OP_ACCEL  = 2'd1,
        OP_POS    = 2'd2,
        OP_SMOOTH = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  servo_id;
        logic [15:0] position;
        logic [15:0] speed;
        logic [7:0]  acceleration;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } res_t;

    // one write packet waiting to be serialized
    typedef struct packed {
        logic [7:0]      id;
        logic [7:0]      addr;
        logic [3:0][7:0] data;
        logic            four;
        logic            last;
    } pkt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* src/sbwpf_queue.sv */
// ----------------------------------------------------------------------------
// sbwpf_queue
// small packet descriptor queue between the front and back ends
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbwpf_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sbwpf_pkg::pkt_t       push_data,
    input  logic                  pop,
    output sbwpf_pkg::pkt_t       pop_data,
    output sbwpf_pkg::q_status_t  status
);
    import sbwpf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pkt_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

    `SBWPF_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !status.full)
    `SBWPF_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !status.empty)
    `SBWPF_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

/* src/sbwpf_front.sv */
// ----------------------------------------------------------------------------
// sbwpf_front
// accepts commands and splits them into write packet descriptors
// ----------------------------------------------------------------------------
module sbwpf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sbwpf_pkg::cmd_t       command,
    input  sbwpf_pkg::q_status_t  q_status,
    output logic                  push,
    output sbwpf_pkg::pkt_t       push_data
);
    import sbwpf_pkg::*;

    logic pend_valid_reg;
    logic pend_valid_next;
    pkt_t pend_reg;
    pkt_t pend_next;
    logic accept;
    pkt_t first_pkt;
    pkt_t pos_pkt;

    assign busy   = pend_valid_reg || q_status.full;
    assign accept = start && !busy;

    always_comb
    begin
        pos_pkt.id      = command.servo_id;
        pos_pkt.addr    = ADDR_POS;
        pos_pkt.data[0] = command.position[7:0];
        pos_pkt.data[1] = command.position[15:8];
        pos_pkt.data[2] = command.speed[7:0];
        pos_pkt.data[3] = command.speed[15:8];
        pos_pkt.four    = 1'b1;
        pos_pkt.last    = 1'b1;

        first_pkt         = '0;
        first_pkt.id      = command.servo_id;
        first_pkt.last    = 1'b1;
        unique case (command.opcode)
            OP_TORQUE:
            begin
                first_pkt.addr    = ADDR_TORQUE;
                first_pkt.data[0] = 8'd1;
            end
            OP_ACCEL:
            begin
                first_pkt.addr    = ADDR_ACCEL;
                first_pkt.data[0] = command.acceleration;
            end
            OP_POS:
            begin
                first_pkt = pos_pkt;
            end
            OP_SMOOTH:
            begin
                first_pkt.addr    = ADDR_ACCEL;
                first_pkt.data[0] = command.acceleration;
                first_pkt.last    = 1'b0;
            end
            default:
            begin
                first_pkt = pos_pkt;
            end
        endcase
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_data       = first_pkt;
        if (pend_valid_reg)
        begin
            // second packet of a smooth move
            if (!q_status.full)
            begin
                push            = 1'b1;
                push_data       = pend_reg;
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            push = 1'b1;
            if (command.opcode == OP_SMOOTH)
            begin
                pend_valid_next = 1'b1;
                pend_next       = pos_pkt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

/* src/sbwpf_back.sv */
// ----------------------------------------------------------------------------
// sbwpf_back
// serializes packet descriptors into bytes and appends the checksum
// ----------------------------------------------------------------------------
module sbwpf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbwpf_pkg::q_status_t  q_status,
    input  sbwpf_pkg::pkt_t       pop_data,
    output logic                  pop,
    output logic                  strobe,
    output sbwpf_pkg::res_t       result
);
    import sbwpf_pkg::*;

    logic       cur_valid_reg;
    logic       cur_valid_next;
    pkt_t       cur_reg;
    pkt_t       cur_next;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       strobe_reg;
    logic       strobe_next;
    res_t       result_reg;
    res_t       result_next;
    logic [7:0] len;
    logic [3:0] last_idx;
    logic [3:0] data_idx;
    logic       at_last;
    logic [7:0] cur_byte;

    always_comb
    begin
        len      = cur_reg.four ? LEN_LONG : LEN_SHORT;
        last_idx = cur_reg.four ? LAST_LONG : LAST_SHORT;
        at_last  = (idx_reg == last_idx);
        data_idx = idx_reg - DATA_START;
        unique case (idx_reg)
            4'd0, 4'd1: cur_byte = HDR_BYTE;
            4'd2:       cur_byte = cur_reg.id;
            4'd3:       cur_byte = len;
            4'd4:       cur_byte = INSTR_WRITE;
            4'd5:       cur_byte = cur_reg.addr;
            default:    cur_byte = at_last ? ~sum_reg : cur_reg.data[data_idx[1:0]];
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        sum_next       = (idx_reg < 4'd2) ? 8'd0 : sum_reg + cur_byte;
        strobe_next    = 1'b0;
        result_next    = result_reg;
        pop            = 1'b0;
        if (cur_valid_reg)
        begin
            strobe_next           = 1'b1;
            result_next.out_byte  = cur_byte;
            result_next.last_byte = at_last && cur_reg.last;
            if (at_last)
            begin
                pop            = !q_status.empty;
                cur_valid_next = !q_status.empty;
                cur_next       = pop_data;
                idx_next       = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (!q_status.empty)
        begin
            pop            = 1'b1;
            cur_valid_next = 1'b1;
            cur_next       = pop_data;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

/* src/servo_bus_write_packet_framer.sv */
// ----------------------------------------------------------------------------
// servo_bus_write_packet_framer
// turns servo commands into write packet byte streams
// ----------------------------------------------------------------------------
// a command is transferred on the edge where start is high and busy is low;
// command carries opcode, servo id, position, speed and acceleration.
// result bytes leave on result, one per cycle, each valid for exactly one
// cycle while strobe is high; last_byte marks the final byte of a command.
// when the serializer is free, the first byte of a command goes through the
// queue, the serializer's packet register and its output registers. a command
// yields 8 bytes (torque, acceleration), 11 bytes (position) or 19 bytes
// (smooth move), sent by the one-byte-per-cycle serializer. a queue of
// QUEUE_DEPTH packets lets commands be taken while earlier ones are still
// being sent; busy rises when it is full, and after a smooth move until its
// second packet is queued. reset empties the queue and drops any packet in
// flight; no strobe follows. the receiver cannot stall, so bytes are never
// held back once started.
// ----------------------------------------------------------------------------
module servo_bus_write_packet_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sbwpf_pkg::cmd_t  command,
    output logic             strobe,
    output sbwpf_pkg::res_t  result
);
    import sbwpf_pkg::*;

    logic      push;
    pkt_t      push_data;
    logic      pop;
    pkt_t      pop_data;
    q_status_t q_status;

    sbwpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    sbwpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    sbwpf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .strobe   (strobe),
        .result   (result)
    );

endmodule
